// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ASSERT_RANGE(lbl, clk, rst_n, ante, sig, lim) \
	`ASSERT_IMPLIES(lbl, clk, rst_n, ante, ((sig) <= (lim)) && ((sig) >= -(lim)))
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_RANGE(lbl, clk, rst_n, ante, sig, lim)
`endif
`endif

// ===== hw/rtl/gai_pkg.sv =====
// types and constants of the gyro angle integrator
package gai_pkg;

	localparam int RATE_W   = 16;
	localparam int MS_W     = 10;
	localparam int DB_W     = 15;
	localparam int ANG_W    = 25;
	localparam int SUM_W    = 24;
	localparam int CNT_W    = 7;
	localparam int CRATE_W  = 17;
	localparam int TSUM_W   = 18;
	localparam int PROD_W   = 29;
	localparam int MAG_W    = 28;
	localparam int Y_W      = 30;
	localparam int Q125_W   = 23;
	localparam int INC_W    = 29;
	localparam int NSTG     = 6;
	localparam int NLANE    = 3;
	localparam int IN_W     = 64;
	localparam int OUT_W    = 80;

	// bias divide: x * ceil(2^29 / n) >> 29 is exact for x below 2^22
	localparam int BDIV_SH  = 29;
	localparam int BX_W     = 22;
	localparam int BRCP_W   = 30;

	// angle divide by 125: y * ceil(2^37 / 125) >> 37, exact for y below 2^30
	localparam int RCP125_SH = 37;
	localparam int RCP125_W  = 31;
	localparam logic [RCP125_W-1:0] RCP125 = 31'd1099511628;
	localparam logic [Y_W-1:0] HALF125 = 30'd62;

	localparam logic signed [ANG_W-1:0] DEG180 = 25'sd11796480;
	localparam logic [DB_W-1:0] DB_RST = 15'd160;
	localparam logic signed [RATE_W-1:0] BIAS_RST [NLANE] = '{16'sd80, 16'sd144, 16'sd288};

	typedef struct packed {
		logic [NSTG:1] en;
		logic [NSTG:1] adv;
	} pipe_ctl_t;

	typedef struct packed {
		logic clr;
		logic act;
		logic done;
	} cal_ctl_t;

endpackage

// ===== hw/rtl/gai_calib.sv =====
// calibration sequencer: sample count and active flag shared by the lanes
module gai_calib #(
	parameter int CALIB_SAMPLES = 100
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              start,
	output gai_pkg::cal_ctl_t cal,
	output logic              calibrating
);

	logic                      active_q;
	logic [gai_pkg::CNT_W-1:0] cnt_q;
	logic [gai_pkg::CNT_W-1:0] cnt_n;

	always_comb begin
		cal.clr     = start & ~active_q;
		cal.act     = active_q | start;
		cnt_n       = cal.clr ? gai_pkg::CNT_W'(1) : cnt_q + gai_pkg::CNT_W'(1);
		cal.done    = cal.act & (cnt_n >= gai_pkg::CNT_W'(CALIB_SAMPLES));
		calibrating = cal.act & ~cal.done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else if (accept) begin
			if (cal.done) begin
				active_q <= 1'b0;
				cnt_q    <= '0;
			end else if (cal.act) begin
				active_q <= 1'b1;
				cnt_q    <= cnt_n;
			end
		end
	end

endmodule

// ===== hw/rtl/gai_lane.sv =====
// one axis: bias averaging, dead band, trapezoidal integration and wrap
module gai_lane #(
	parameter int                 CALIB_SAMPLES = 100,
	parameter logic signed [15:0] BIAS_INIT     = 16'sd0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gai_pkg::pipe_ctl_t                  ctl,
	input  gai_pkg::cal_ctl_t                   cal,
	input  logic [gai_pkg::DB_W-1:0]            dead_band,
	input  logic signed [gai_pkg::RATE_W-1:0]   raw,
	input  logic                                done_s2,
	input  logic [gai_pkg::MS_W-1:0]            ms_s3,
	input  logic                                clr_s5,
	output logic signed [gai_pkg::ANG_W-1:0]    angle_nx
);

	localparam logic [gai_pkg::BX_W-1:0] HALF_C = gai_pkg::BX_W'(CALIB_SAMPLES / 2);
	localparam logic [gai_pkg::BRCP_W-1:0] BRCP_C =
		gai_pkg::BRCP_W'(((2 ** gai_pkg::BDIV_SH) + CALIB_SAMPLES - 1) / CALIB_SAMPLES);
	localparam int BPROD_W = gai_pkg::BX_W + gai_pkg::BRCP_W;
	localparam int YPROD_W = gai_pkg::Y_W + gai_pkg::RCP125_W;
	localparam logic signed [gai_pkg::ANG_W+5:0] DEG_X = (gai_pkg::ANG_W+6)'(gai_pkg::DEG180);

	// stage 0: running sums
	logic signed [gai_pkg::SUM_W-1:0] sum_q, sum_n, sum_s1;
	logic signed [gai_pkg::RATE_W-1:0] raw_s1, raw_s2;

	// stage 1: bias divide
	logic                               neg_s1;
	logic [gai_pkg::SUM_W-1:0]          abs_s1;
	logic [gai_pkg::BX_W-1:0]           bx;
	logic [BPROD_W-1:0]                 bprod;
	logic [gai_pkg::RATE_W-1:0]         q_s2;
	logic                               neg_s2;

	// stage 2: bias correction and dead band
	logic signed [gai_pkg::RATE_W-1:0]  bias_q, bias_e;
	logic [gai_pkg::RATE_W-1:0]         nb;
	logic signed [gai_pkg::CRATE_W-1:0] crate, rate_s3;
	logic [gai_pkg::CRATE_W-1:0]        cmag;
	logic                               integ, integ_s3;

	// stage 3: trapezoid product
	logic signed [gai_pkg::CRATE_W-1:0] prev_q;
	logic signed [gai_pkg::TSUM_W-1:0]  tsum;
	logic signed [gai_pkg::PROD_W-1:0]  ts_x, ms_x, tprod, prod_s4;
	logic                               integ_s4;

	// stage 4: divide by 125
	logic                               neg4;
	logic [gai_pkg::PROD_W-1:0]         abs4;
	logic [gai_pkg::MAG_W-1:0]          mag4;
	logic [gai_pkg::Y_W-1:0]            y4;
	logic [YPROD_W-1:0]                 yprod;
	logic [gai_pkg::Q125_W-1:0]         q_s5;
	logic [gai_pkg::INC_W-1:0]          m2_s5;
	logic                               neg_s5, integ_s5;

	// stage 5: angle accumulate and wrap
	logic signed [gai_pkg::ANG_W-1:0]   angle_q;
	logic [gai_pkg::INC_W-1:0]          incm;
	logic signed [gai_pkg::INC_W:0]     inc;
	logic signed [gai_pkg::ANG_W+5:0]   asum;
	logic signed [gai_pkg::ANG_W-1:0]   awrap;

	always_comb begin
		sum_n = (cal.clr ? '0 : sum_q) + {{(gai_pkg::SUM_W-gai_pkg::RATE_W){raw[15]}}, raw};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.adv[1]) begin
			if (cal.done) begin
				sum_q <= '0;
			end else if (cal.act) begin
				sum_q <= sum_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			raw_s1 <= raw;
			sum_s1 <= sum_n;
		end
	end

	// rounded to nearest, ties away from zero
	always_comb begin
		neg_s1 = sum_s1[gai_pkg::SUM_W-1];
		abs_s1 = neg_s1 ? (~sum_s1 + gai_pkg::SUM_W'(1)) : sum_s1;
		bx     = abs_s1[gai_pkg::BX_W-1:0] + HALF_C;
		bprod  = BPROD_W'(bx) * BPROD_W'(BRCP_C);
	end

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			q_s2   <= bprod[gai_pkg::BDIV_SH+gai_pkg::RATE_W-1:gai_pkg::BDIV_SH];
			neg_s2 <= neg_s1;
			raw_s2 <= raw_s1;
		end
	end

	always_comb begin
		nb     = neg_s2 ? (~q_s2 + gai_pkg::RATE_W'(1)) : q_s2;
		bias_e = done_s2 ? $signed(nb) : bias_q;
		crate  = {raw_s2[15], raw_s2} - {bias_e[15], bias_e};
		cmag   = crate[gai_pkg::CRATE_W-1] ? (~crate + gai_pkg::CRATE_W'(1)) : crate;
		integ  = cmag > {2'b00, dead_band};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= BIAS_INIT;
		end else if (ctl.adv[3]) begin
			bias_q <= bias_e;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			rate_s3  <= crate;
			integ_s3 <= integ;
		end
	end

	always_comb begin
		tsum  = {rate_s3[16], rate_s3} + {prev_q[16], prev_q};
		ts_x  = {{(gai_pkg::PROD_W-gai_pkg::TSUM_W){tsum[17]}}, tsum};
		ms_x  = {{(gai_pkg::PROD_W-gai_pkg::MS_W){1'b0}}, ms_s3};
		tprod = ts_x * ms_x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (ctl.adv[4] && integ_s3) begin
			prev_q <= rate_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			prod_s4  <= tprod;
			integ_s4 <= integ_s3;
		end
	end

	// p * 256 / 125 = 2p + (6p + 62) / 125 on the magnitude
	always_comb begin
		neg4  = prod_s4[gai_pkg::PROD_W-1];
		abs4  = neg4 ? (~prod_s4 + gai_pkg::PROD_W'(1)) : prod_s4;
		mag4  = abs4[gai_pkg::MAG_W-1:0];
		y4    = {mag4, 2'b00} + {1'b0, mag4, 1'b0} + gai_pkg::HALF125;
		yprod = YPROD_W'(y4) * YPROD_W'(gai_pkg::RCP125);
	end

	always_ff @(posedge clk) begin
		if (ctl.en[5]) begin
			q_s5     <= yprod[gai_pkg::RCP125_SH+gai_pkg::Q125_W-1:gai_pkg::RCP125_SH];
			m2_s5    <= {mag4, 1'b0};
			neg_s5   <= neg4;
			integ_s5 <= integ_s4;
		end
	end

	always_comb begin
		incm = m2_s5 + {{(gai_pkg::INC_W-gai_pkg::Q125_W){1'b0}}, q_s5};
		inc  = neg_s5 ? -$signed({1'b0, incm}) : $signed({1'b0, incm});
		asum = {{6{angle_q[gai_pkg::ANG_W-1]}}, angle_q} + {inc[gai_pkg::INC_W], inc};
		if (asum <= -DEG_X) begin
			awrap = gai_pkg::DEG180;
		end else if (asum > DEG_X) begin
			awrap = -gai_pkg::DEG180;
		end else begin
			awrap = asum[gai_pkg::ANG_W-1:0];
		end
		angle_nx = integ_s5 ? awrap : angle_q;
		if (clr_s5) begin
			angle_nx = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
		end else if (ctl.adv[6]) begin
			angle_q <= angle_nx;
		end
	end

endmodule

// ===== hw/rtl/gyro_angle_integrator.sv =====
// Top level of the gyro angle integrator. Each input word carries one
// three-axis rate sample and its elapsed time; each gives exactly one output
// word with the three wrapped angles and the calibration flag. Three axis
// lanes run side by side through a six-stage pipeline, so a word is taken
// every clock while m_axis_tready is high or a stage is empty. Each lane has
// two reciprocal multipliers (bias divide by the sample count, angle divide
// by 125), each followed by a register. The output word sits in its own
// register and empty stages keep taking input while it waits. dead_band
// must be written by the user only while the block is idle; the block does
// not enforce this. There is no clearing pass after reset.
`include "assert_macros.svh"

module gyro_angle_integrator #(
	parameter int CALIB_SAMPLES = 100
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// rate_yaw, rate_pitch, rate_roll, elapsed_ms, start_calibration, reset_angles
	input  logic [gai_pkg::IN_W-1:0]     s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// angle_yaw, angle_pitch, angle_roll, calibrating
	output logic [gai_pkg::OUT_W-1:0]    m_axis_tdata,
	input  logic                         cfg_wr_en,
	input  logic [gai_pkg::DB_W-1:0]     cfg_wr_data
);

	gai_pkg::pipe_ctl_t               ctl;
	gai_pkg::cal_ctl_t                cal;
	logic [gai_pkg::NSTG:1]           vld_q;
	logic [gai_pkg::NSTG:1]           en;
	logic [gai_pkg::NSTG:1]           adv;
	logic [gai_pkg::DB_W-1:0]         dead_band_q;
	logic                             calibrating;

	logic signed [gai_pkg::RATE_W-1:0] raw_in [gai_pkg::NLANE];
	logic signed [gai_pkg::ANG_W-1:0]  ang_nx [gai_pkg::NLANE];
	logic [gai_pkg::MS_W-1:0]          ms_in;
	logic                              start_in, clr_in;

	logic [gai_pkg::MS_W-1:0] ms_s1, ms_s2, ms_s3;
	logic clr_s1, clr_s2, clr_s3, clr_s4, clr_s5;
	logic cal_s1, cal_s2, cal_s3, cal_s4, cal_s5;
	logic done_s1, done_s2;

	logic signed [gai_pkg::ANG_W-1:0] out_yaw_q, out_pitch_q, out_roll_q;
	logic                             out_cal_q;

	assign raw_in[0] = s_axis_tdata[15:0];
	assign raw_in[1] = s_axis_tdata[31:16];
	assign raw_in[2] = s_axis_tdata[47:32];
	assign ms_in     = s_axis_tdata[57:48];
	assign start_in  = s_axis_tdata[58];
	assign clr_in    = s_axis_tdata[59];

	// stage loads when empty or when the stage after it moves
	always_comb begin
		en[gai_pkg::NSTG] = ~vld_q[gai_pkg::NSTG] | m_axis_tready;
		for (int k = gai_pkg::NSTG - 1; k >= 1; k--) begin
			en[k] = ~vld_q[k] | en[k+1];
		end
		adv[1] = en[1] & s_axis_tvalid;
		for (int k = 2; k <= gai_pkg::NSTG; k++) begin
			adv[k] = en[k] & vld_q[k-1];
		end
		ctl.en  = en;
		ctl.adv = adv;
	end

	assign s_axis_tready = en[1];
	assign m_axis_tvalid = vld_q[gai_pkg::NSTG];
	assign m_axis_tdata  = {4'b0000, out_cal_q, out_roll_q, out_pitch_q, out_yaw_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= s_axis_tvalid;
			end
			for (int k = 2; k <= gai_pkg::NSTG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_band_q <= gai_pkg::DB_RST;
		end else if (cfg_wr_en) begin
			dead_band_q <= cfg_wr_data;
		end
	end

	// side band travelling beside the lanes
	always_ff @(posedge clk) begin
		if (en[1]) begin
			ms_s1   <= ms_in;
			clr_s1  <= clr_in;
			cal_s1  <= calibrating;
			done_s1 <= cal.done;
		end
		if (en[2]) begin
			ms_s2   <= ms_s1;
			clr_s2  <= clr_s1;
			cal_s2  <= cal_s1;
			done_s2 <= done_s1;
		end
		if (en[3]) begin
			ms_s3  <= ms_s2;
			clr_s3 <= clr_s2;
			cal_s3 <= cal_s2;
		end
		if (en[4]) begin
			clr_s4 <= clr_s3;
			cal_s4 <= cal_s3;
		end
		if (en[5]) begin
			clr_s5 <= clr_s4;
			cal_s5 <= cal_s4;
		end
		if (en[6]) begin
			out_yaw_q   <= ang_nx[0];
			out_pitch_q <= ang_nx[1];
			out_roll_q  <= ang_nx[2];
			out_cal_q   <= cal_s5;
		end
	end

	gai_calib #(
		.CALIB_SAMPLES (CALIB_SAMPLES)
	) u_calib (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (adv[1]),
		.start       (start_in),
		.cal         (cal),
		.calibrating (calibrating)
	);

	for (genvar i = 0; i < gai_pkg::NLANE; i++) begin : g_lane
		gai_lane #(
			.CALIB_SAMPLES (CALIB_SAMPLES),
			.BIAS_INIT     (gai_pkg::BIAS_RST[i])
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.cal       (cal),
			.dead_band (dead_band_q),
			.raw       (raw_in[i]),
			.done_s2   (done_s2),
			.ms_s3     (ms_s3),
			.clr_s5    (clr_s5),
			.angle_nx  (ang_nx[i])
		);
	end

	`ASSERT_RANGE(a_yaw_range, clk, arst_n, m_axis_tvalid, out_yaw_q, gai_pkg::DEG180)
	`ASSERT_IMPLIES(a_full_stall, clk, arst_n, (&vld_q) && !m_axis_tready, !s_axis_tready)
	`ASSERT_IMPLIES(a_out_src, clk, arst_n, $rose(m_axis_tvalid), $past(vld_q[5]))

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the gyro angle integrator stream block
`timescale 1ns / 1ps

module testbench;

	localparam int      CAL_N      = 100;
	localparam longint  HALF_TURN  = 180 * 65536;
	localparam int      LIMIT      = 400000;
	localparam int      MAX_SHOWN  = 10;

	// fields from the lowest bit up: yaw, pitch, roll, ms, start_cal, clear
	typedef struct packed {
		logic                     clear;
		logic                     start_cal;
		logic [gai_pkg::MS_W-1:0] ms;
		logic signed [15:0]       roll;
		logic signed [15:0]       pitch;
		logic signed [15:0]       yaw;
	} sample_t;

	// fields from the lowest bit up: yaw, pitch, roll, calibrating
	typedef struct packed {
		logic                             calibrating;
		logic signed [gai_pkg::ANG_W-1:0] roll;
		logic signed [gai_pkg::ANG_W-1:0] pitch;
		logic signed [gai_pkg::ANG_W-1:0] yaw;
	} angles_t;

	logic                      clk;
	logic                      arst_n;
	logic                      s_axis_tvalid;
	logic                      s_axis_tready;
	logic [gai_pkg::IN_W-1:0]  s_axis_tdata;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready;
	logic [gai_pkg::OUT_W-1:0] m_axis_tdata;
	logic                      cfg_wr_en;
	logic [gai_pkg::DB_W-1:0]  cfg_wr_data;

	gyro_angle_integrator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	// predictor state
	longint  bias_est [3];
	longint  bias_acc [3];
	int      cal_count;
	bit      cal_busy;
	longint  last_rate [3];
	longint  angle_est [3];
	longint  dead_band_est;

	angles_t expected_angles [$];

	int      words_in;
	int      words_checked;
	int      failures;
	int      calibrations_done;
	int      angle_wraps;
	int      cycle_count;
	int      hold_req;
	int      hold_left;
	bit      no_idle;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint div_nearest(input longint n, input longint d);
		if (n >= 0)
			return (n + d / 2) / d;
		return -((-n + d / 2) / d);
	endfunction

	function automatic angles_t predict_angles(input sample_t s);
		longint  raw [3];
		longint  rate;
		longint  mag;
		longint  a;
		longint  ms_l;
		angles_t r;
		raw[0] = s.yaw;
		raw[1] = s.pitch;
		raw[2] = s.roll;
		ms_l   = s.ms;
		if (s.start_cal && !cal_busy) begin
			cal_busy  = 1'b1;
			cal_count = 0;
			for (int i = 0; i < 3; i++)
				bias_acc[i] = 0;
		end
		if (cal_busy) begin
			for (int i = 0; i < 3; i++)
				bias_acc[i] += raw[i];
			cal_count++;
			if (cal_count >= CAL_N) begin
				for (int i = 0; i < 3; i++) begin
					bias_est[i] = div_nearest(bias_acc[i], CAL_N);
					bias_acc[i] = 0;
				end
				cal_count = 0;
				cal_busy  = 1'b0;
				calibrations_done++;
			end
		end
		for (int i = 0; i < 3; i++) begin
			rate = raw[i] - bias_est[i];
			mag  = (rate < 0) ? -rate : rate;
			if (mag > dead_band_est) begin
				a = angle_est[i] + div_nearest((rate + last_rate[i]) * ms_l * 256, 125);
				if (a <= -HALF_TURN) begin
					a = HALF_TURN;
					angle_wraps++;
				end else if (a > HALF_TURN) begin
					a = -HALF_TURN;
					angle_wraps++;
				end
				angle_est[i] = a;
				last_rate[i] = rate;
			end
			if (s.clear)
				angle_est[i] = 0;
		end
		r.yaw         = gai_pkg::ANG_W'(angle_est[0]);
		r.pitch       = gai_pkg::ANG_W'(angle_est[1]);
		r.roll        = gai_pkg::ANG_W'(angle_est[2]);
		r.calibrating = cal_busy;
		return r;
	endfunction

	function automatic sample_t make_sample(input int y, input int p, input int r,
			input int ms, input bit st, input bit clr);
		sample_t s;
		s.yaw       = 16'(y);
		s.pitch     = 16'(p);
		s.roll      = 16'(r);
		s.ms        = gai_pkg::MS_W'(ms);
		s.start_cal = st;
		s.clear     = clr;
		return s;
	endfunction

	function automatic int random_rate(input int axis);
		int mode;
		mode = $urandom_range(0, 99);
		if (mode < 40)
			return int'(bias_est[axis]) + $urandom_range(0, 800) - 400;
		if (mode < 80)
			return $urandom_range(0, 8000) - 4000;
		return $urandom_range(0, 65535) - 32768;
	endfunction

	function automatic sample_t random_sample(input int start_odds);
		int mode;
		int ms;
		mode = $urandom_range(0, 99);
		if (mode < 50)
			ms = $urandom_range(0, 1023);
		else if (mode < 85)
			ms = $urandom_range(0, 20);
		else
			ms = ($urandom_range(0, 1)) ? 1023 : 0;
		return make_sample(random_rate(0), random_rate(1), random_rate(2), ms,
			$urandom_range(1, start_odds) == 1, $urandom_range(0, 29) == 0);
	endfunction

	task automatic send_sample(input sample_t s);
		int gap;
		gap = 0;
		if (!no_idle)
			while ($urandom_range(0, 99) < 36)
				gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= {4'b0, s};
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		expected_angles.push_back(predict_angles(s));
		words_in++;
	endtask

	task automatic send_random(input int count, input int start_odds);
		for (int k = 0; k < count; k++)
			send_sample(random_sample(start_odds));
	endtask

	// pause the sender until every outstanding word has come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_angles.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_dead_band(input logic [gai_pkg::DB_W-1:0] value);
		drain();
		cfg_wr_data <= value;
		cfg_wr_en   <= 1'b1;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		dead_band_est = value;
	endtask

	task automatic note_failure(input string msg);
		failures++;
		if (failures <= MAX_SHOWN)
			$display("%s", msg);
	endtask

	task automatic test_extremes();
		send_sample(make_sample(0, 0, 0, 1023, 0, 0));
		send_sample(make_sample(32767, 32767, 32767, 0, 0, 0));
		send_sample(make_sample(-32768, -32768, -32768, 1023, 0, 0));
		send_sample(make_sample(-32768, -32768, -32768, 1023, 0, 0));
		send_sample(make_sample(32767, 32767, 32767, 1023, 0, 0));
		send_sample(make_sample(32767, 32767, 32767, 1023, 0, 0));
		send_sample(make_sample(32767, -32768, 1000, 700, 0, 1));
		send_sample(make_sample(1000, -1000, 3000, 1, 0, 0));
		send_sample(make_sample(-1500, 2500, -700, 3, 0, 0));
		send_sample(make_sample(-1, 1, 0, 512, 0, 0));
	endtask

	task automatic test_dead_band_edges();
		// at the band edge the axis holds still, one step beyond it integrates
		send_sample(make_sample(80 + 160, 144 - 161, 288 - 160, 500, 0, 0));
		send_sample(make_sample(80 + 161, 144 - 160, 288 + 161, 1, 0, 0));
		send_sample(make_sample(80 - 160, 144 + 161, 288 + 160, 900, 0, 0));
		send_sample(make_sample(80 - 161, 144 + 160, 288 - 161, 33, 0, 0));
		send_sample(make_sample(2000, -2000, 4000, 0, 0, 0));
		send_sample(make_sample(80, 144, 288, 1023, 0, 0));
		send_sample(make_sample(-3000, 3000, -3000, 250, 0, 1));
	endtask

	task automatic test_calibration();
		int r;
		// yaw and pitch sums land on a half, roll takes arbitrary values
		for (int k = 0; k < CAL_N; k++) begin
			r = $urandom_range(0, 65535) - 32768;
			if (k == CAL_N - 1)
				send_sample(make_sample(57, -57, r, $urandom_range(0, 1023), 0, 0));
			else
				send_sample(make_sample(7, -7, r, $urandom_range(0, 1023),
					k == 0 || k == 50, 0));
		end
		send_sample(make_sample(8 + 200, -8 - 200, 0, 400, 0, 0));
		send_sample(make_sample(8, -8, 500, 400, 0, 0));
	endtask

	task automatic test_dead_band_sweep();
		write_dead_band(15'd0);
		send_random(105, 150);
		write_dead_band(15'd32767);
		send_random(105, 150);
		write_dead_band(gai_pkg::DB_W'($urandom_range(1, 32766)));
		send_random(105, 150);
		write_dead_band(15'd1000);
		send_random(105, 150);
		write_dead_band(15'd160);
	endtask

	task automatic test_recalibration();
		send_sample(make_sample(random_rate(0), random_rate(1), random_rate(2),
			$urandom_range(0, 1023), 1, 0));
		send_random(109, 40);
	endtask

	task automatic test_back_to_back();
		no_idle = 1'b1;
		send_random(120, 150);
		no_idle = 1'b0;
	endtask

	task automatic test_output_stall();
		hold_req = 300;
		send_random(60, 150);
		drain();
		send_random(20, 150);
	endtask

	// receiver side
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 36);
		end
	end

	always @(posedge clk) begin
		angles_t got;
		angles_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[$bits(angles_t)-1:0];
			if (expected_angles.size() == 0) begin
				note_failure($sformatf("unexpected word: yaw %0d pitch %0d roll %0d cal %0b",
					got.yaw, got.pitch, got.roll, got.calibrating));
			end else begin
				want = expected_angles.pop_front();
				if (got.yaw !== want.yaw || got.pitch !== want.pitch ||
						got.roll !== want.roll || got.calibrating !== want.calibrating)
					note_failure($sformatf(
						"word %0d: expected yaw %0d pitch %0d roll %0d cal %0b, got yaw %0d pitch %0d roll %0d cal %0b",
						words_checked, want.yaw, want.pitch, want.roll, want.calibrating,
						got.yaw, got.pitch, got.roll, got.calibrating));
			end
			words_checked++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("[gyro_angle_integrator] ERROR");
			$finish;
		end
	end

	initial begin
		clk           = 1'b0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		m_axis_tready <= 1'b0;
		cfg_wr_en     <= 1'b0;
		cfg_wr_data   <= '0;
		bias_est[0]   = 80;
		bias_est[1]   = 144;
		bias_est[2]   = 288;
		for (int i = 0; i < 3; i++) begin
			bias_acc[i]  = 0;
			last_rate[i] = 0;
			angle_est[i] = 0;
		end
		cal_count     = 0;
		cal_busy      = 1'b0;
		dead_band_est = 160;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_dead_band_edges();
		test_calibration();
		test_dead_band_sweep();
		test_recalibration();
		test_back_to_back();
		test_output_stall();

		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d words in, %0d words checked, %0d bias calibrations, %0d angle wraps",
			words_in, words_checked, calibrations_done, angle_wraps);
		$display("dead band swept from 0 to 32767, with output hold-off and back-to-back traffic");
		if (failures == 0 && expected_angles.size() == 0) begin
			$display("[gyro_angle_integrator] OK");
		end else begin
			$display("[gyro_angle_integrator] ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/gai_pkg.sv
hw/rtl/gai_calib.sv
hw/rtl/gai_lane.sv
hw/rtl/gyro_angle_integrator.sv
tb/sv/testbench.sv
